>>> rtl/ssmq_pkg.sv
`default_nettype none
package ssmq_pkg;

    localparam int SLOTS       = 64;
    localparam int SLOT_W      = 6;
    localparam int MAX_PROCS   = 16;
    localparam int RANK_W      = 4;
    localparam int SLOT_BYTES  = 64;
    localparam int POS_W       = 7;
    localparam int INBOX_DEPTH = 16;
    localparam int ICNT_W      = 5;
    localparam int FCNT_W      = 7;
    localparam int PAY_AW      = 12;
    localparam int META_W      = 8;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_TOO_LONG = 3'd1;
    localparam logic [2:0] STAT_BAD_RANK = 3'd2;
    localparam logic [2:0] STAT_INACTIVE = 3'd3;
    localparam logic [2:0] STAT_NO_SLOT  = 3'd4;
    localparam logic [2:0] STAT_FULL     = 3'd5;
    localparam logic [2:0] STAT_EMPTY    = 3'd6;
    localparam logic [2:0] STAT_MISMATCH = 3'd7;

    localparam logic CFG_PROC_COUNT  = 1'b0;
    localparam logic CFG_ACTIVE_MASK = 1'b1;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND,
        ST_SEND_END,
        ST_RX_META,
        ST_RX_RD,
        ST_RX_OUT,
        ST_STAT
    } state_t;

endpackage
`default_nettype wire

>>> rtl/ssmq_ram.sv
`default_nettype none
module ssmq_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/shared_slot_mailbox_queues_core.sv
`default_nettype none
// channel   dir  handshake            payload
// s_        in   s_tvalid / s_tready  s_tdata, s_tuser (opcode), s_tlast (last_byte)
// m_        out  m_tvalid / m_tready  m_tdata, m_tlast (last_result)
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one transaction at a time through a small sequencer around three memories
// each send byte passes ST_SEND, the last also ST_SEND_END for the status result
// a receive reads the slot metadata in ST_RX_META, then per payload byte steps
// through ST_RX_RD and ST_RX_OUT, as the payload memory read is registered
// reset clears the free list, inbox counts and the open send; no clearing pass
// a stalled result register holds the sequencer in the state that produces it
module shared_slot_mailbox_queues_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // own_rank, peer_rank, elem_size, count, data_byte
    input  wire logic        s_tuser,   // opcode
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // status, payload_byte, sender, length_bytes
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    import ssmq_pkg::*;

    // configuration
    logic [4:0]  proc_count_reg;
    logic [15:0] active_mask_reg;

    // fields of the incoming transaction
    logic              op_in;
    logic [RANK_W-1:0] own_in;
    logic [4:0]        peer_in;
    logic [3:0]        esz_in;
    logic [6:0]        cnt_in;
    logic [7:0]        byte_in;
    logic [10:0]       len_in;

    assign op_in   = s_tuser;
    assign own_in  = s_tdata[3:0];
    assign peer_in = s_tdata[8:4];
    assign esz_in  = s_tdata[12:9];
    assign cnt_in  = s_tdata[19:13];
    assign byte_in = s_tdata[27:20];
    assign len_in  = {7'd0, esz_in} * {4'd0, cnt_in};

    state_t state_reg, state_next;

    // free list and inboxes
    logic [SLOT_W-1:0] free_head_reg, free_tail_reg;
    logic [FCNT_W-1:0] free_count_reg;
    logic [SLOT_W-1:0] inbox_head_reg  [MAX_PROCS];
    logic [SLOT_W-1:0] inbox_tail_reg  [MAX_PROCS];
    logic [ICNT_W-1:0] inbox_count_reg [MAX_PROCS];

    // open send run
    logic              send_open_reg;
    logic [SLOT_W-1:0] send_slot_reg;
    logic [POS_W-1:0]  send_pos_reg;
    logic [2:0]        send_err_reg;
    logic [RANK_W-1:0] send_dest_reg;
    logic              pop_pending_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;

    // receive in progress
    logic [RANK_W-1:0] own_reg;
    logic [3:0]        esz_reg;
    logic [10:0]       len_reg;
    logic [SLOT_W-1:0] rx_slot_reg;
    logic [RANK_W-1:0] rx_sender_reg;
    logic [POS_W-1:0]  rx_idx_reg;
    logic [2:0]        stat_reg;

    // result register
    logic        m_valid_reg;
    logic [2:0]  o_status_reg;
    logic [7:0]  o_payload_reg;
    logic [3:0]  o_sender_reg;
    logic [9:0]  o_len_reg;
    logic        o_last_reg;

    // memory ports
    logic              pay_we, pay_re;
    logic [PAY_AW-1:0] pay_waddr, pay_raddr;
    logic [7:0]        pay_rdata;
    logic              meta_we, meta_re;
    logic [SLOT_W-1:0] meta_waddr, meta_raddr;
    logic [META_W-1:0] meta_wdata, meta_rdata;
    logic              nxt_we, nxt_re;
    logic [SLOT_W-1:0] nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;

    // slot_next starts chained in slot order; unwritten entries read as i plus one
    logic [SLOTS-1:0]  nxt_vld_reg;
    logic              nxt_rd_vld_reg;
    logic [SLOT_W-1:0] nxt_rd_addr_reg;
    logic [SLOT_W-1:0] nxt_value;

    assign nxt_value = nxt_rd_vld_reg ? nxt_rdata : nxt_rd_addr_reg + SLOT_W'(1);

    logic        s_fire, out_free, out_load;
    logic [2:0]  first_err;
    logic        rx_esz_ok;
    logic        dest_full;
    logic        rx_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    // result register takes a new result in these states once it is free
    assign out_load  = out_free && (state_reg inside {ST_SEND_END, ST_RX_OUT, ST_STAT});
    assign rx_esz_ok = (meta_rdata[3:0] == esz_reg);
    assign dest_full = (inbox_count_reg[send_dest_reg] >= ICNT_W'(INBOX_DEPTH));
    assign rx_last   = ({4'd0, rx_idx_reg} + 11'd1 == len_reg);

    // checks on the first byte of a send run, in priority order
    always_comb begin
        if (len_in > 11'(SLOT_BYTES)) begin
            first_err = STAT_TOO_LONG;
        end else if (peer_in >= proc_count_reg || peer_in >= 5'(MAX_PROCS)) begin
            first_err = STAT_BAD_RANK;
        end else if (!active_mask_reg[peer_in[3:0]]) begin
            first_err = STAT_INACTIVE;
        end else if (free_count_reg == '0) begin
            first_err = STAT_NO_SLOT;
        end else begin
            first_err = STAT_OK;
        end
    end

    // sequencer and memory controls
    always_comb begin
        state_next = state_reg;
        pay_we     = 1'b0;
        pay_waddr  = {send_slot_reg, send_pos_reg[5:0]};
        pay_re     = 1'b0;
        pay_raddr  = {rx_slot_reg, rx_idx_reg[5:0]};
        meta_we    = 1'b0;
        meta_waddr = free_head_reg;
        meta_wdata = {own_in, esz_in};
        meta_re    = 1'b0;
        meta_raddr = inbox_head_reg[own_in];
        nxt_we     = 1'b0;
        nxt_waddr  = free_tail_reg;
        nxt_wdata  = send_slot_reg;
        nxt_re     = 1'b0;
        nxt_raddr  = free_head_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (op_in == OP_SEND) begin
                        state_next = ST_SEND;
                        if (!send_open_reg && first_err == STAT_OK) begin
                            meta_we = 1'b1;
                            nxt_re  = 1'b1;
                        end
                    end else if (len_in > 11'(SLOT_BYTES)
                                 || inbox_count_reg[own_in] == '0) begin
                        state_next = ST_STAT;
                    end else begin
                        state_next = ST_RX_META;
                        meta_re    = 1'b1;
                        nxt_re     = 1'b1;
                        nxt_raddr  = inbox_head_reg[own_in];
                    end
                end
            end
            ST_SEND: begin
                pay_we     = (send_err_reg == STAT_OK) && (send_pos_reg < POS_W'(SLOT_BYTES));
                state_next = last_reg ? ST_SEND_END : ST_IDLE;
            end
            ST_SEND_END: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (send_err_reg == STAT_OK) begin
                        if (dest_full) begin
                            nxt_we = (free_count_reg != '0);
                        end else begin
                            nxt_we    = (inbox_count_reg[send_dest_reg] != '0);
                            nxt_waddr = inbox_tail_reg[send_dest_reg];
                        end
                    end
                end
            end
            ST_RX_META: begin
                nxt_wdata = rx_slot_reg;
                if (!rx_esz_ok || len_reg == '0) begin
                    state_next = ST_STAT;
                end else begin
                    state_next = ST_RX_RD;
                end
                if (rx_esz_ok) begin
                    nxt_we = (free_count_reg != '0);
                end
            end
            ST_RX_RD: begin
                pay_re     = 1'b1;
                state_next = ST_RX_OUT;
            end
            ST_RX_OUT: begin
                if (out_free) begin
                    state_next = rx_last ? ST_IDLE : ST_RX_RD;
                end
            end
            ST_STAT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proc_count_reg  <= 5'(MAX_PROCS);
            active_mask_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PROC_COUNT:  proc_count_reg  <= cfg_data[4:0];
                CFG_ACTIVE_MASK: active_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // slot_next valid bits and read tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nxt_vld_reg <= '0;
        end else if (nxt_we) begin
            nxt_vld_reg[nxt_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (nxt_re) begin
            nxt_rd_vld_reg  <= nxt_vld_reg[nxt_raddr];
            nxt_rd_addr_reg <= nxt_raddr;
        end
    end

    // inbox head and tail have no reset, written before use
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SEND_END && out_free && send_err_reg == STAT_OK && !dest_full) begin
            if (inbox_count_reg[send_dest_reg] == '0) begin
                inbox_head_reg[send_dest_reg] <= send_slot_reg;
            end
            inbox_tail_reg[send_dest_reg] <= send_slot_reg;
        end
        if (state_reg == ST_RX_META && rx_esz_ok) begin
            inbox_head_reg[own_reg] <= nxt_value;
        end
    end

    // control state: free list, inbox counts, send run, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg   <= '0;
            free_tail_reg   <= SLOT_W'(SLOTS - 1);
            free_count_reg  <= FCNT_W'(SLOTS);
            for (int i = 0; i < MAX_PROCS; i++) begin
                inbox_count_reg[i] <= '0;
            end
            send_open_reg   <= 1'b0;
            send_slot_reg   <= '0;
            send_pos_reg    <= '0;
            send_err_reg    <= STAT_OK;
            send_dest_reg   <= '0;
            pop_pending_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && op_in == OP_SEND && !send_open_reg) begin
                        send_open_reg <= 1'b1;
                        send_pos_reg  <= '0;
                        send_err_reg  <= first_err;
                        send_dest_reg <= peer_in[3:0];
                        if (first_err == STAT_OK) begin
                            send_slot_reg   <= free_head_reg;
                            free_count_reg  <= free_count_reg - FCNT_W'(1);
                            pop_pending_reg <= 1'b1;
                        end
                    end
                end
                ST_SEND: begin
                    pop_pending_reg <= 1'b0;
                    if (pop_pending_reg && free_count_reg != '0) begin
                        free_head_reg <= nxt_value;
                    end
                    if (pay_we) begin
                        send_pos_reg <= send_pos_reg + POS_W'(1);
                    end
                    if (last_reg) begin
                        send_open_reg <= 1'b0;
                    end
                end
                ST_SEND_END: begin
                    if (out_free) begin
                        if (send_err_reg == STAT_OK) begin
                            if (dest_full) begin
                                // slot goes back to the tail of the free list
                                if (free_count_reg == '0) begin
                                    free_head_reg <= send_slot_reg;
                                end
                                free_tail_reg <= send_slot_reg;
                                if (free_count_reg < FCNT_W'(SLOTS)) begin
                                    free_count_reg <= free_count_reg + FCNT_W'(1);
                                end
                            end else begin
                                inbox_count_reg[send_dest_reg] <=
                                    inbox_count_reg[send_dest_reg] + ICNT_W'(1);
                            end
                        end
                    end
                end
                ST_RX_META: begin
                    if (rx_esz_ok) begin
                        inbox_count_reg[own_reg] <= inbox_count_reg[own_reg] - ICNT_W'(1);
                        if (free_count_reg == '0) begin
                            free_head_reg <= rx_slot_reg;
                        end
                        free_tail_reg <= rx_slot_reg;
                        if (free_count_reg < FCNT_W'(SLOTS)) begin
                            free_count_reg <= free_count_reg + FCNT_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers of the transaction in flight and of the result
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    byte_reg      <= byte_in;
                    last_reg      <= s_tlast;
                    own_reg       <= own_in;
                    esz_reg       <= esz_in;
                    len_reg       <= len_in;
                    rx_slot_reg   <= inbox_head_reg[own_in];
                    rx_sender_reg <= '0;
                    rx_idx_reg    <= '0;
                    stat_reg      <= (len_in > 11'(SLOT_BYTES)) ? STAT_TOO_LONG : STAT_EMPTY;
                end
            end
            ST_SEND_END: begin
                if (out_free) begin
                    o_status_reg  <= (send_err_reg == STAT_OK && dest_full) ? STAT_FULL
                                                                            : send_err_reg;
                    o_payload_reg <= '0;
                    o_sender_reg  <= '0;
                    o_len_reg     <= '0;
                    o_last_reg    <= 1'b1;
                end
            end
            ST_RX_META: begin
                if (rx_esz_ok) begin
                    rx_sender_reg <= meta_rdata[7:4];
                    stat_reg      <= STAT_OK;
                end else begin
                    stat_reg      <= STAT_MISMATCH;
                end
            end
            ST_RX_OUT: begin
                if (out_free) begin
                    o_status_reg  <= STAT_OK;
                    o_payload_reg <= pay_rdata;
                    o_sender_reg  <= rx_sender_reg;
                    o_len_reg     <= len_reg[9:0];
                    o_last_reg    <= rx_last;
                    rx_idx_reg    <= rx_idx_reg + POS_W'(1);
                end
            end
            ST_STAT: begin
                if (out_free) begin
                    o_status_reg  <= stat_reg;
                    o_payload_reg <= '0;
                    o_sender_reg  <= rx_sender_reg;
                    o_len_reg     <= len_reg[9:0];
                    o_last_reg    <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, o_len_reg, o_sender_reg, o_payload_reg, o_status_reg};
    assign m_tlast  = o_last_reg;

    // payload bytes, slot_size bytes per slot
    ssmq_ram #(.DATA_W(8), .ADDR_W(PAY_AW)) u_payload (
        .aclk    (aclk),
        .wr_en   (pay_we),
        .wr_addr (pay_waddr),
        .wr_data (byte_reg),
        .rd_en   (pay_re),
        .rd_addr (pay_raddr),
        .rd_data (pay_rdata)
    );

    // sender and element size per slot
    ssmq_ram #(.DATA_W(META_W), .ADDR_W(SLOT_W)) u_meta (
        .aclk    (aclk),
        .wr_en   (meta_we),
        .wr_addr (meta_waddr),
        .wr_data (meta_wdata),
        .rd_en   (meta_re),
        .rd_addr (meta_raddr),
        .rd_data (meta_rdata)
    );

    // link field shared by the free list and the inboxes
    ssmq_ram #(.DATA_W(SLOT_W), .ADDR_W(SLOT_W)) u_next (
        .aclk    (aclk),
        .wr_en   (nxt_we),
        .wr_addr (nxt_waddr),
        .wr_data (nxt_wdata),
        .rd_en   (nxt_re),
        .rd_addr (nxt_raddr),
        .rd_data (nxt_rdata)
    );

    // free list never holds more slots than exist
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= FCNT_W'(SLOTS))
        else $error("free count beyond pool size");

    // an accepted transaction always moves the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg != ST_IDLE)
        else $error("sequencer idle after accepted transaction");

    // closing a send run presents exactly one final status result
    a_send_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND_END && out_free) |=> (m_tvalid && m_tlast))
        else $error("send run closed without final result");

    // a pop is only pending right after the first byte of a send run
    a_pop_state: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_pending_reg |-> (state_reg == ST_SEND && send_open_reg))
        else $error("slot pop pending outside send");

endmodule
`default_nettype wire
